FILE: src/tesp_pkg.sv
// Shared types and constants for the tree entry stream parser.
package tesp_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int NAME_BYTES  = 256;
    localparam int HASH_BYTES  = 32;
    localparam int MODE_CHARS  = 16;

    localparam int DATA_W     = 8;
    localparam int POS_W      = 8;
    localparam int COUNT_W    = 11;
    localparam int MODE_W     = 32;
    localparam int MODE_LEN_W = 5;

    localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [4:0]        OCTAL_HIGH = 5'b00110;  // '0'..'7' share these bits

    typedef enum logic [1:0]
    {
        PH_MODE = 2'd0,
        PH_NAME = 2'd1,
        PH_HASH = 2'd2
    } phase_t;

    typedef enum logic [2:0]
    {
        ROLE_MODE    = 3'd0,
        ROLE_SEP     = 3'd1,
        ROLE_NAME    = 3'd2,
        ROLE_NUL     = 3'd3,
        ROLE_HASH    = 3'd4,
        ROLE_IGNORED = 3'd5
    } byte_role_t;

    typedef enum logic [1:0]
    {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed
    {
        phase_t                  phase;
        logic [MODE_LEN_W-1:0]   mode_cnt;
        logic [MODE_W-1:0]       mode_acc;
        logic                    octal_stopped;
        logic [POS_W-1:0]        field_cnt;
        logic [COUNT_W-1:0]      completed;
        logic                    error_seen;
    } parse_state_t;

    typedef struct packed
    {
        byte_role_t              byte_role;
        logic [POS_W-1:0]        field_position;
        logic [COUNT_W-1:0]      entry_index;
        logic [MODE_W-1:0]       mode_value;
        logic                    entry_done;
        logic [COUNT_W-1:0]      entry_count;
        status_t                 status;
    } parse_result_t;

endpackage

FILE: src/tesp_if.sv
// Byte input and tagged result channel interfaces.
interface tesp_in_if;
    logic                          valid;
    logic                          ready;
    logic [tesp_pkg::DATA_W-1:0]   data_byte;
    logic                          first_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

interface tesp_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    byte_role;
    logic [tesp_pkg::POS_W-1:0]    field_position;
    logic [tesp_pkg::COUNT_W-1:0]  entry_index;
    logic [tesp_pkg::MODE_W-1:0]   mode_value;
    logic                          entry_done;
    logic [tesp_pkg::COUNT_W-1:0]  entry_count;
    logic [1:0]                    status;

    modport source (output valid, output byte_role, output field_position,
                    output entry_index, output mode_value, output entry_done,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input byte_role, input field_position,
                    input entry_index, input mode_value, input entry_done,
                    input entry_count, input status, output ready);
endinterface

FILE: src/tesp_step.sv
// Per-byte next-state and tag logic of the tree entry parser.
module tesp_step
(
    input  tesp_pkg::parse_state_t          cur,
    input  logic [tesp_pkg::DATA_W-1:0]     data_byte,
    input  logic                            first_byte,
    input  logic                            last_byte,
    output tesp_pkg::parse_state_t          nxt,
    output tesp_pkg::parse_result_t         res
);

    tesp_pkg::parse_state_t s;
    logic active;
    logic is_octal;
    logic mode_full;
    logic name_full;
    logic hash_full;
    logic at_boundary;

    function automatic logic [tesp_pkg::COUNT_W-1:0] COUNT_MAX();
        return tesp_pkg::COUNT_W'(tesp_pkg::MAX_ENTRIES);
    endfunction

    assign is_octal  = (data_byte[7:3] == tesp_pkg::OCTAL_HIGH);

    always_comb
    begin
        s = cur;
        if (first_byte)
        begin
            s.phase         = tesp_pkg::PH_MODE;
            s.mode_cnt      = '0;
            s.mode_acc      = '0;
            s.octal_stopped = 1'b0;
            s.field_cnt     = '0;
            s.completed     = '0;
            s.error_seen    = 1'b0;
        end

        mode_full = (({1'b0, s.mode_cnt} + 6'd1) >= 6'(tesp_pkg::MODE_CHARS));
        name_full = (({1'b0, s.field_cnt} + 9'd1) >= 9'(tesp_pkg::NAME_BYTES));
        hash_full = (({1'b0, s.field_cnt} + 9'd1) >= 9'(tesp_pkg::HASH_BYTES));

        nxt                = s;
        res.byte_role      = tesp_pkg::ROLE_IGNORED;
        res.field_position = '0;
        res.entry_index    = s.completed;
        res.mode_value     = '0;
        res.entry_done     = 1'b0;

        active = !s.error_seen && (s.completed < COUNT_MAX());

        if (active)
        begin
            case (s.phase)
                tesp_pkg::PH_MODE:
                begin
                    res.field_position = {3'b000, s.mode_cnt};
                    if (data_byte == tesp_pkg::CHAR_SPACE)
                    begin
                        res.byte_role = tesp_pkg::ROLE_SEP;
                        nxt.phase     = tesp_pkg::PH_NAME;
                        nxt.field_cnt = '0;
                    end
                    else
                    begin
                        res.byte_role = tesp_pkg::ROLE_MODE;
                        if (!s.octal_stopped && is_octal)
                            nxt.mode_acc = {s.mode_acc[tesp_pkg::MODE_W-4:0], data_byte[2:0]};
                        else
                            nxt.octal_stopped = 1'b1;
                        nxt.mode_cnt = s.mode_cnt + 5'd1;
                        if (mode_full)
                            nxt.error_seen = 1'b1;
                    end
                end
                tesp_pkg::PH_NAME:
                begin
                    res.field_position = s.field_cnt;
                    if (data_byte == tesp_pkg::CHAR_NUL)
                    begin
                        res.byte_role = tesp_pkg::ROLE_NUL;
                        nxt.phase     = tesp_pkg::PH_HASH;
                        nxt.field_cnt = '0;
                    end
                    else
                    begin
                        res.byte_role = tesp_pkg::ROLE_NAME;
                        if (name_full)
                            nxt.error_seen = 1'b1;
                        else
                            nxt.field_cnt = s.field_cnt + 8'd1;
                    end
                end
                default:
                begin
                    // hash field; the unused phase code behaves the same
                    res.byte_role      = tesp_pkg::ROLE_HASH;
                    res.field_position = s.field_cnt;
                    if (hash_full)
                    begin
                        res.entry_done = 1'b1;
                        nxt.completed  = s.completed + 11'd1;
                    end
                    else
                    begin
                        nxt.field_cnt = s.field_cnt + 8'd1;
                    end
                end
            endcase

            res.mode_value = nxt.mode_acc;

            if (res.entry_done)
            begin
                nxt.phase         = tesp_pkg::PH_MODE;
                nxt.mode_cnt      = '0;
                nxt.mode_acc      = '0;
                nxt.octal_stopped = 1'b0;
                nxt.field_cnt     = '0;
            end
        end

        at_boundary = (nxt.phase == tesp_pkg::PH_MODE) && (nxt.mode_cnt == '0);
        if (last_byte && !nxt.error_seen && (nxt.completed < COUNT_MAX()) && !at_boundary)
            nxt.error_seen = 1'b1;

        if (nxt.error_seen)
            res.status = tesp_pkg::ST_ERROR;
        else if ((nxt.completed >= COUNT_MAX()) || last_byte)
            res.status = tesp_pkg::ST_DONE;
        else
            res.status = tesp_pkg::ST_BUSY;

        res.entry_count = nxt.completed;
    end

endmodule

FILE: src/tree_entry_stream_parser.sv
// Top level of the tree entry stream parser: parse state and result register.
//
// Takes one byte of a serialised tree object per cycle and returns one tagged
// result per byte, in the cycle after the input transfer. The parse state
// (phase, mode text, field counter, entry count, sticky error) is updated in
// the same cycle the byte is taken, so bytes flow at one per clock for as long
// as the result side keeps taking them; a single result register parts the two
// channels and input is held off only while that register is full and stalled.
// Assert first_byte on the opening byte of each object to restart the parse.
module tree_entry_stream_parser
(
    input  logic         clk,
    input  logic         rst_n,
    tesp_in_if.sink      in_stream,
    tesp_out_if.source   out_stream
);

    tesp_pkg::parse_state_t  state_reg;
    tesp_pkg::parse_state_t  state_next;
    tesp_pkg::parse_result_t result_reg;
    tesp_pkg::parse_result_t result_next;
    logic                    out_valid_reg;
    logic                    in_xfer;

    assign in_stream.ready = !out_valid_reg || out_stream.ready;
    assign in_xfer         = in_stream.valid && in_stream.ready;

    tesp_step u_step
    (
        .cur        (state_reg),
        .data_byte  (in_stream.data_byte),
        .first_byte (in_stream.first_byte),
        .last_byte  (in_stream.last_byte),
        .nxt        (state_next),
        .res        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= tesp_pkg::PH_MODE;
            state_reg.mode_cnt      <= '0;
            state_reg.mode_acc      <= '0;
            state_reg.octal_stopped <= 1'b0;
            state_reg.field_cnt     <= '0;
            state_reg.completed     <= '0;
            state_reg.error_seen    <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                state_reg <= state_next;
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            result_reg <= result_next;
    end

    assign out_stream.valid          = out_valid_reg;
    assign out_stream.byte_role      = result_reg.byte_role;
    assign out_stream.field_position = result_reg.field_position;
    assign out_stream.entry_index    = result_reg.entry_index;
    assign out_stream.mode_value     = result_reg.mode_value;
    assign out_stream.entry_done     = result_reg.entry_done;
    assign out_stream.entry_count    = result_reg.entry_count;
    assign out_stream.status         = result_reg.status;

endmodule

FILE: src/tesp_checker.sv
// Port-level assertions for the tree entry stream parser, with bind.
module tesp_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [2:0]                     byte_role,
    input  logic [tesp_pkg::POS_W-1:0]     field_position,
    input  logic [tesp_pkg::COUNT_W-1:0]   entry_index,
    input  logic [tesp_pkg::MODE_W-1:0]    mode_value,
    input  logic                           entry_done,
    input  logic [tesp_pkg::COUNT_W-1:0]   entry_count
);

    // stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_role) && $stable(entry_count))
        else $error("result changed while stalled");

    // single result register: no transfer in while it is full and stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_role == 3'(tesp_pkg::ROLE_IGNORED)) |->
        (field_position == '0) && (mode_value == '0) && !entry_done)
        else $error("ignored byte carries field data");

    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_done |->
        (byte_role == 3'(tesp_pkg::ROLE_HASH)) && (entry_count == entry_index + 11'd1))
        else $error("entry completion inconsistent");

    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_done |-> (entry_count == entry_index))
        else $error("entry count moved without completion");

endmodule

bind tree_entry_stream_parser tesp_checker u_tesp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_stream.ready),
    .out_valid      (out_stream.valid),
    .out_ready      (out_stream.ready),
    .byte_role      (out_stream.byte_role),
    .field_position (out_stream.field_position),
    .entry_index    (out_stream.entry_index),
    .mode_value     (out_stream.mode_value),
    .entry_done     (out_stream.entry_done),
    .entry_count    (out_stream.entry_count)
);

FILE: sim/tree_parse_checker.sv
// Byte tag predictor and result comparison for the tree entry stream parser.
module tree_parse_checker
(
    input  logic clk,
    input  logic rst_n,
    tesp_in_if   in_ch,
    tesp_out_if  out_ch,
    output int   mismatches,
    output int   pending,
    output int   checked,
    output int   entries_closed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tesp_pkg::DATA_W-1:0] CHAR_ZERO  = "0";
    localparam logic [tesp_pkg::DATA_W-1:0] CHAR_SEVEN = "7";
    localparam int                          REPORT_CAP = 50;

    // predicted parse state
    tesp_pkg::phase_t                     ph;
    logic [tesp_pkg::MODE_LEN_W-1:0]      mode_cnt;
    logic [tesp_pkg::MODE_W-1:0]          mode_acc;
    logic                                 octal_stopped;
    logic [tesp_pkg::POS_W-1:0]           field_cnt;
    logic [tesp_pkg::COUNT_W-1:0]         completed;
    logic                                 error_seen;

    tesp_pkg::parse_result_t expected_tags[$];
    tesp_pkg::parse_result_t want;

    function automatic void clear_entry();
        ph            = tesp_pkg::PH_MODE;
        mode_cnt      = '0;
        mode_acc      = '0;
        octal_stopped = 1'b0;
        field_cnt     = '0;
    endfunction

    function automatic void restart_parse();
        clear_entry();
        completed  = '0;
        error_seen = 1'b0;
    endfunction

    function automatic tesp_pkg::parse_result_t tag_byte(
        input logic [tesp_pkg::DATA_W-1:0] b, input logic first, input logic last);
        tesp_pkg::parse_result_t r;
        logic                    closes;
        r.byte_role      = tesp_pkg::ROLE_IGNORED;
        r.field_position = '0;
        r.mode_value     = '0;
        r.entry_done     = 1'b0;
        closes           = 1'b0;
        if (first)
            restart_parse();
        r.entry_index = completed;
        if (!error_seen && completed < tesp_pkg::MAX_ENTRIES)
        begin
            case (ph)
                tesp_pkg::PH_MODE:
                begin
                    r.field_position = tesp_pkg::POS_W'(mode_cnt);
                    if (b == tesp_pkg::CHAR_SPACE)
                    begin
                        r.byte_role = tesp_pkg::ROLE_SEP;
                        ph          = tesp_pkg::PH_NAME;
                        field_cnt   = '0;
                    end
                    else
                    begin
                        r.byte_role = tesp_pkg::ROLE_MODE;
                        if (!octal_stopped && b >= CHAR_ZERO && b <= CHAR_SEVEN)
                            mode_acc = (mode_acc << 3) + tesp_pkg::MODE_W'(b - CHAR_ZERO);
                        else
                            octal_stopped = 1'b1;
                        mode_cnt = mode_cnt + 1'b1;
                        if (int'(r.field_position) + 1 >= tesp_pkg::MODE_CHARS)
                            error_seen = 1'b1;
                    end
                end
                tesp_pkg::PH_NAME:
                begin
                    r.field_position = field_cnt;
                    if (b == tesp_pkg::CHAR_NUL)
                    begin
                        r.byte_role = tesp_pkg::ROLE_NUL;
                        ph          = tesp_pkg::PH_HASH;
                        field_cnt   = '0;
                    end
                    else
                    begin
                        r.byte_role = tesp_pkg::ROLE_NAME;
                        if (int'(field_cnt) + 1 >= tesp_pkg::NAME_BYTES)
                            error_seen = 1'b1;
                        else
                            field_cnt = field_cnt + 1'b1;
                    end
                end
                default:
                begin
                    r.byte_role      = tesp_pkg::ROLE_HASH;
                    r.field_position = field_cnt;
                    if (int'(field_cnt) + 1 >= tesp_pkg::HASH_BYTES)
                    begin
                        closes    = 1'b1;
                        completed = completed + 1'b1;
                    end
                    else
                        field_cnt = field_cnt + 1'b1;
                end
            endcase
            r.mode_value = mode_acc;
            r.entry_done = closes;
            if (closes)
                clear_entry();
        end
        // object ending part-way through an entry
        if (last && !error_seen && completed < tesp_pkg::MAX_ENTRIES &&
            !(ph == tesp_pkg::PH_MODE && mode_cnt == '0))
            error_seen = 1'b1;
        if (error_seen)
            r.status = tesp_pkg::ST_ERROR;
        else if (completed >= tesp_pkg::MAX_ENTRIES || last)
            r.status = tesp_pkg::ST_DONE;
        else
            r.status = tesp_pkg::ST_BUSY;
        r.entry_count = completed;
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [tesp_pkg::MODE_W-1:0] exp_val,
                                        input logic [tesp_pkg::MODE_W-1:0] got);
        if (got !== exp_val)
        begin
            if (mismatches < REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, exp_val, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parse();
            expected_tags.delete();
            mismatches     = 0;
            pending        = 0;
            checked        = 0;
            entries_closed = 0;
        end
        else
        begin
            // results first: a tag always trails its byte by at least one transfer
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_tags.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                        $error("tag transfer with no byte outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    checked++;
                    if (want.entry_done)
                        entries_closed++;
                    check_field("byte_role", want.byte_role, out_ch.byte_role);
                    check_field("field_position", want.field_position,
                                out_ch.field_position);
                    check_field("entry_index", want.entry_index, out_ch.entry_index);
                    check_field("mode_value", want.mode_value, out_ch.mode_value);
                    check_field("entry_done", want.entry_done, out_ch.entry_done);
                    check_field("entry_count", want.entry_count, out_ch.entry_count);
                    check_field("status", want.status, out_ch.status);
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_tags.push_back(tag_byte(in_ch.data_byte, in_ch.first_byte,
                                                 in_ch.last_byte));
            pending = expected_tags.size();
        end
    end

endmodule

FILE: sim/tb_tree_entry_stream_parser.sv
// Stimulus, handshake pacing and verdict for the tree entry stream parser.
module tb_tree_entry_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tesp_pkg::DATA_W-1:0] CHAR_ZERO    = "0";
    localparam int                          RANDOM_BYTES = 1250;

    logic                        clk;
    logic                        rst_n;
    int                          tx_idle_pct;
    int                          rx_idle_pct;
    int                          sent;
    int                          mismatches;
    int                          pending;
    int                          checked;
    int                          entries_closed;
    logic [tesp_pkg::DATA_W-1:0] obj_bytes[$];

    tesp_in_if  byte_ch();
    tesp_out_if tag_ch();

    tree_entry_stream_parser dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (byte_ch),
        .out_stream (tag_ch)
    );

    tree_parse_checker tag_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (byte_ch),
        .out_ch         (tag_ch),
        .mismatches     (mismatches),
        .pending        (pending),
        .checked        (checked),
        .entries_closed (entries_closed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb_tree_entry_stream_parser: done, errors");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        tag_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tag_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [tesp_pkg::DATA_W-1:0] b, input logic first,
                             input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.first_byte <= first;
        byte_ch.last_byte  <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_object(input int n, input bit with_last);
        for (int i = 0; i < n; i++)
            send_byte(obj_bytes[i], i == 0, with_last && i == n - 1);
        obj_bytes.delete();
    endtask

    function automatic void add_entry(input int mode_chars, input bit octal_only,
                                      input int name_size);
        logic [tesp_pkg::DATA_W-1:0] c;
        for (int i = 0; i < mode_chars; i++)
        begin
            if (octal_only || $urandom_range(0, 3) != 0)
                c = CHAR_ZERO + tesp_pkg::DATA_W'($urandom_range(0, 7));
            else
                do c = tesp_pkg::DATA_W'($urandom_range(0, 255));
                while (c == tesp_pkg::CHAR_SPACE);
            obj_bytes.push_back(c);
        end
        obj_bytes.push_back(tesp_pkg::CHAR_SPACE);
        for (int i = 0; i < name_size; i++)
            obj_bytes.push_back(tesp_pkg::DATA_W'($urandom_range(1, 255)));
        obj_bytes.push_back(tesp_pkg::CHAR_NUL);
        for (int i = 0; i < tesp_pkg::HASH_BYTES; i++)
            obj_bytes.push_back(tesp_pkg::DATA_W'($urandom_range(0, 255)));
    endfunction

    initial
    begin
        int kind;
        int n_ent;
        int bad_ent;
        int mode_chars;
        int name_size;
        int cut;

        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.first_byte = 1'b0;
        byte_ch.last_byte  = 1'b0;
        tx_idle_pct        = 31;
        rx_idle_pct        = 67;
        sent               = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: octal stop, separator, name extremes, truncation, ignore, restart
        send_byte("1", 1'b1, 1'b0);
        send_byte("0", 1'b0, 1'b0);
        send_byte("9", 1'b0, 1'b0);
        send_byte("7", 1'b0, 1'b0);
        send_byte(tesp_pkg::CHAR_SPACE, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(tesp_pkg::CHAR_NUL, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(tesp_pkg::CHAR_SPACE, 1'b1, 1'b0);
        send_byte(tesp_pkg::CHAR_NUL, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte("7", 1'b1, 1'b1);
        send_byte(8'h80, 1'b0, 1'b1);

        while (sent < RANDOM_BYTES)
        begin
            if (sent >= 2 * RANDOM_BYTES / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (sent >= RANDOM_BYTES / 3)
            begin
                tx_idle_pct = 67;
                rx_idle_pct = 31;
            end
            kind = $urandom_range(0, 99);
            if (kind < 90)
            begin
                n_ent   = $urandom_range(1, 4);
                bad_ent = $urandom_range(0, n_ent - 1);
                for (int e = 0; e < n_ent; e++)
                begin
                    mode_chars = ($urandom_range(0, 3) == 0)
                                 ? $urandom_range(7, tesp_pkg::MODE_CHARS - 1)
                                 : $urandom_range(0, 6);
                    name_size  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                             : $urandom_range(0, 12);
                    if (e == bad_ent && kind >= 80 && kind < 85)
                        mode_chars = $urandom_range(tesp_pkg::MODE_CHARS,
                                                    tesp_pkg::MODE_CHARS + 2);
                    if (e == bad_ent && kind >= 85)
                        name_size = $urandom_range(tesp_pkg::NAME_BYTES - 1,
                                                   tesp_pkg::NAME_BYTES + 2);
                    add_entry(mode_chars, $urandom_range(0, 2) != 0, name_size);
                end
                if (kind >= 70 && kind < 80)
                begin
                    cut = $urandom_range(1, obj_bytes.size() - 1);
                    send_object(cut, 1'b1);
                end
                else
                    send_object(obj_bytes.size(), kind >= 70 || $urandom_range(0, 9) != 0);
            end
            else
            begin
                // loose bytes, mostly carrying on from whatever came before
                n_ent = $urandom_range(1, 8);
                for (int i = 0; i < n_ent; i++)
                    send_byte(tesp_pkg::DATA_W'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            end
        end

        // one clean object to close the stream
        add_entry(6, 1'b1, 4);
        send_object(obj_bytes.size(), 1'b1);
        byte_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (4) @(posedge clk);
        $display("tb: %0d byte tags compared over directed and random object streams",
                 checked);
        $display("tb: %0d entries closed, %0d field mismatches", entries_closed, mismatches);
        if (mismatches == 0)
            $display("tb_tree_entry_stream_parser: done, clean");
        else
            $display("tb_tree_entry_stream_parser: done, errors");
        $finish;
    end

endmodule
